// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/fsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fsa_pkg
// Types and constants of the fuzzy set aggregator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int DIST_W    = FRAC_BITS + 3;
  localparam int CFG_IDX_W = 2;

  typedef logic [Q_W-1:0]           q_t;
  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam q_t ONE_Q = q_t'(1) << FRAC_BITS;

  localparam cfg_idx_t REG_MODE      = cfg_idx_t'(0);
  localparam cfg_idx_t REG_TOLERANCE = cfg_idx_t'(1);

  typedef enum logic [2:0] {
    MODE_MAX           = 3'd0,
    MODE_ALG_UNION     = 3'd1,
    MODE_BND_UNION     = 3'd2,
    MODE_DRASTIC_UNION = 3'd3,
    MODE_MIN           = 3'd4,
    MODE_PRODUCT       = 3'd5,
    MODE_BND_INTER     = 3'd6,
    MODE_DRASTIC_INTER = 3'd7
  } mode_t;

  localparam q_t TOLERANCE_RST = q_t'(1);

endpackage

`default_nettype wire

// ----- rtl/core/fsa_if.sv -----
// ----------------------------------------------------------------------------
// fsa_if
// Valid/ready channels: distance requests, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fsa_in_if import fsa_pkg::*;;
  logic  valid;
  logic  ready;
  dist_t distance_in;
  logic  last;

  modport source (output valid, output distance_in, output last, input ready);
  modport sink   (input valid, input distance_in, input last, output ready);
endinterface

interface fsa_out_if import fsa_pkg::*;;
  logic valid;
  logic ready;
  q_t   distance_out;

  modport source (output valid, output distance_out, input ready);
  modport sink   (input valid, input distance_out, output ready);
endinterface

interface fsa_cfg_if import fsa_pkg::*;;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  q_t       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fuzzy_set_aggregator.sv -----
// A request marked last gives its registered result in the cycle after acceptance.
// Throughput: one request per cycle unless a result waits; the fold (clamps,
// a 16x16 multiply, adds and subtracts) is combinational from the request port to the state registers.
// A finished result waits in the output register and stalls new requests until taken.
// Reset (rst, synchronous): mode max, tolerance 1 LSB (2^-16), group empty, no result.
// ----------------------------------------------------------------------------
// fuzzy_set_aggregator
// Folds clamped similarities per group with the selected fuzzy union or
// intersection and emits one minus the fold on the last request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fuzzy_set_aggregator import fsa_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  fsa_cfg_if.sink    cfg,
  fsa_in_if.sink     sample,
  fsa_out_if.source  result
);

  mode_t mode;
  q_t    tolerance;
  q_t    running_similarity;
  logic  group_open;
  logic  out_valid;
  q_t    out_data;

  logic  take;
  q_t    dist_clamp;
  q_t    sim;
  q_t    acc_a;
  q_t    mul;
  logic [2*FRAC_BITS-1:0] prod;
  logic [Q_W:0] sum;
  logic [Q_W:0] alg;
  q_t    fold;

  assign cfg.ready    = 1'b1;
  assign sample.ready = !out_valid || result.ready;
  assign result.valid = out_valid;
  assign result.distance_out = out_data;
  assign take = sample.valid && sample.ready;

  always_comb begin
    if (sample.distance_in < 0) begin
      dist_clamp = '0;
    end else if (sample.distance_in > $signed({2'b00, ONE_Q})) begin
      dist_clamp = ONE_Q;
    end else begin
      dist_clamp = q_t'(sample.distance_in[Q_W-1:0]);
    end
    sim = ONE_Q - dist_clamp;

    if (group_open) begin
      acc_a = (running_similarity > ONE_Q) ? ONE_Q : running_similarity;
    end else begin
      acc_a = mode[2] ? ONE_Q : '0;
    end

    prod = acc_a[FRAC_BITS-1:0] * sim[FRAC_BITS-1:0];
    if (acc_a >= ONE_Q) begin
      mul = sim;
    end else if (sim >= ONE_Q) begin
      mul = acc_a;
    end else begin
      mul = q_t'(prod[2*FRAC_BITS-1:FRAC_BITS]);
    end

    sum = {1'b0, acc_a} + {1'b0, sim};
    alg = sum - {1'b0, mul};

    case (mode)
      MODE_MAX:       fold = (acc_a > sim) ? acc_a : sim;
      MODE_ALG_UNION: fold = (alg > {1'b0, ONE_Q}) ? ONE_Q : alg[Q_W-1:0];
      MODE_BND_UNION: fold = (sum > {1'b0, ONE_Q}) ? ONE_Q : sum[Q_W-1:0];
      MODE_DRASTIC_UNION: begin
        if (sim < tolerance) begin
          fold = acc_a;
        end else if (acc_a < tolerance) begin
          fold = sim;
        end else begin
          fold = ONE_Q;
        end
      end
      MODE_MIN:       fold = (acc_a < sim) ? acc_a : sim;
      MODE_PRODUCT:   fold = mul;
      MODE_BND_INTER: begin
        fold = (sum > {1'b0, ONE_Q}) ? q_t'(sum - {1'b0, ONE_Q}) : '0;
      end
      MODE_DRASTIC_INTER: begin
        if ((ONE_Q - sim) < tolerance) begin
          fold = acc_a;
        end else if ((ONE_Q - acc_a) < tolerance) begin
          fold = sim;
        end else begin
          fold = '0;
        end
      end
      default:        fold = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_MAX;
      tolerance <= TOLERANCE_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MODE:      mode      <= mode_t'(cfg.data[2:0]);
        REG_TOLERANCE: tolerance <= cfg.data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_similarity <= '0;
      group_open         <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (take && sample.last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (sample.last) begin
          running_similarity <= '0;
          group_open         <= 1'b0;
        end else begin
          running_similarity <= fold;
          group_open         <= 1'b1;
        end
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (take && sample.last) begin
      out_data <= ONE_Q - fold;
    end
  end

  `ASSERT_ALWAYS(a_run_in_range, running_similarity <= ONE_Q, "running similarity above one")
  `ASSERT_ALWAYS(a_out_in_range, !out_valid || out_data <= ONE_Q, "result above one")
  `ASSERT_NEXT(a_last_gives_result, take && sample.last, out_valid && !group_open, "last request lost its result")
  `ASSERT_NEXT(a_open_after_item, take && !sample.last, group_open && !$rose(out_valid), "group not opened")

endmodule

`default_nettype wire
